### rtl/mwrs_pkg.sv
// ============================================================================
// mwrs_pkg: shared types and constants for the maximum width ramp search
// The request and result payload types and the default sizes live here.
// ============================================================================
package mwrs_pkg;

  // Default sizes of the element store and of one element.
  localparam int unsigned MAX_LEN_DEF    = 1024;
  localparam int unsigned VALUE_BITS_DEF = 16;

  // Fixed widths of the port fields.
  localparam int unsigned IN_VALUE_W = 16;
  localparam int unsigned RAMP_W     = 10;

  // Largest ramp width that the result field can carry.
  localparam int unsigned WIDTH_MAX = 1023;

  // Depth of the queue between the front and the back part.
  localparam int unsigned QUEUE_DEPTH = 2;

  // One request: an array element and the flag that closes the array.
  typedef struct packed {
    logic [IN_VALUE_W-1:0] value;
    logic                  last;
  } in_req_t;

  // One result: the widest ramp and the overflow flag of that array.
  typedef struct packed {
    logic [RAMP_W-1:0] ramp_width;
    logic              overflow;
  } out_res_t;

endpackage

### rtl/mwrs_queue.sv
// ============================================================================
// mwrs_queue: short request queue between the front and the back part
// A small register FIFO; the writer checks full, the reader checks valid.
// ============================================================================
module mwrs_queue #(
  parameter type entry_t = logic
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   valid,
  output entry_t pop_entry
);
  import mwrs_pkg::*;

  localparam int unsigned DEPTH = QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t             slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign valid     = (count_r != '0);
  assign pop_entry = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && valid;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

### rtl/mwrs_front.sv
// ============================================================================
// mwrs_front: request intake and classification
// Counts the elements of the open array, drops those beyond the store size,
// and queues each kept element or closing request with its store address.
// ============================================================================
module mwrs_front #(
  parameter int unsigned MAX_LEN    = mwrs_pkg::MAX_LEN_DEF,
  parameter int unsigned VALUE_BITS = mwrs_pkg::VALUE_BITS_DEF,
  parameter type         entry_t    = logic
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  mwrs_pkg::in_req_t in_req,
  output logic              busy,
  input  logic              q_full,
  output logic              q_push,
  output entry_t            q_entry
);
  import mwrs_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_LEN);
  localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_seen_r, ovf_seen_nxt;
  logic             accept;
  logic             in_bounds;

  assign busy      = q_full;
  assign accept    = start && !busy;
  assign in_bounds = (count_r < CNT_W'(MAX_LEN));

  // A request goes to the queue when it is stored or when it closes the array.
  assign q_push = accept && (in_bounds || in_req.last);

  always_comb begin
    q_entry.value = VALUE_BITS'(in_req.value);
    q_entry.idx   = in_bounds ? count_r[IDX_W-1:0] : IDX_W'(MAX_LEN - 1);
    q_entry.wr    = in_bounds;
    q_entry.last  = in_req.last;
    q_entry.ovf   = ovf_seen_r || !in_bounds;
  end

  // Element count and overflow tracking for the open array.
  always_comb begin
    count_nxt    = count_r;
    ovf_seen_nxt = ovf_seen_r;
    if (accept) begin
      if (in_req.last) begin
        count_nxt    = '0;
        ovf_seen_nxt = 1'b0;
      end else if (in_bounds) begin
        count_nxt = count_r + 1'b1;
      end else begin
        ovf_seen_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      ovf_seen_r <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      ovf_seen_r <= ovf_seen_nxt;
    end
  end

endmodule

### rtl/mwrs_back.sv
// ============================================================================
// mwrs_back: element store, suffix-maximum pass and two-pointer scan
// Writes queued elements to the store; on the closing request it builds the
// suffix-maximum table from the back, runs the scan and issues the result.
// ============================================================================
module mwrs_back #(
  parameter int unsigned MAX_LEN    = mwrs_pkg::MAX_LEN_DEF,
  parameter int unsigned VALUE_BITS = mwrs_pkg::VALUE_BITS_DEF,
  parameter type         entry_t    = logic
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  entry_t             q_entry,
  output logic               q_pop,
  output logic               out_valid,
  output mwrs_pkg::out_res_t out_res
);
  import mwrs_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_LEN);
  localparam int unsigned CMP_W = (IDX_W > RAMP_W) ? IDX_W : RAMP_W;

  typedef enum logic [5:0] {
    ST_LOAD = 6'b000001,
    ST_SUF  = 6'b000010,
    ST_SUFW = 6'b000100,
    ST_RD   = 6'b001000,
    ST_CMP  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [VALUE_BITS-1:0] elem_mem [MAX_LEN];
  logic [VALUE_BITS-1:0] sfx_mem  [MAX_LEN];
  logic [VALUE_BITS-1:0] elem_rd_r;
  logic [VALUE_BITS-1:0] sfx_rd_r;
  logic [VALUE_BITS-1:0] run_max_r, run_max_nxt;
  logic [VALUE_BITS-1:0] new_max;

  logic [IDX_W-1:0] last_idx_r, last_idx_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [IDX_W-1:0] k_d_r;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic [IDX_W-1:0] best_r, best_nxt;
  logic [IDX_W-1:0] gap;
  logic [IDX_W-1:0] elem_addr;
  logic [CMP_W-1:0] best_ext;
  logic             sfx_wr_r, sfx_wr_nxt;
  logic             ovf_r, ovf_nxt;

  assign q_pop     = (state_r == ST_LOAD) && q_valid;
  assign elem_addr = (state_r == ST_SUF) ? k_r : i_r;
  assign new_max   = (elem_rd_r > run_max_r) ? elem_rd_r : run_max_r;
  assign gap       = j_r - i_r;

  // Sequencer for load, suffix pass and scan.
  always_comb begin
    state_nxt    = state_r;
    last_idx_nxt = last_idx_r;
    k_nxt        = k_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    best_nxt     = best_r;
    run_max_nxt  = run_max_r;
    ovf_nxt      = ovf_r;
    sfx_wr_nxt   = 1'b0;
    if (sfx_wr_r) begin
      run_max_nxt = new_max;
    end
    case (state_r)
      ST_LOAD: begin
        if (q_valid && q_entry.last) begin
          last_idx_nxt = q_entry.idx;
          k_nxt        = q_entry.idx;
          ovf_nxt      = q_entry.ovf;
          run_max_nxt  = '0;
          state_nxt    = ST_SUF;
        end
      end
      ST_SUF: begin
        // One store read per cycle, walking from the back.
        sfx_wr_nxt = 1'b1;
        if (k_r == '0) begin
          state_nxt = ST_SUFW;
        end else begin
          k_nxt = k_r - 1'b1;
        end
      end
      ST_SUFW: begin
        i_nxt     = '0;
        j_nxt     = '0;
        best_nxt  = '0;
        state_nxt = ST_RD;
      end
      ST_RD: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if ((i_r < j_r) && (elem_rd_r > sfx_rd_r)) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_RD;
        end else begin
          if (gap > best_r) begin
            best_nxt = gap;
          end
          if (j_r == last_idx_r) begin
            state_nxt = ST_OUT;
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = ST_RD;
          end
        end
      end
      ST_OUT: begin
        state_nxt = ST_LOAD;
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      last_idx_r <= '0;
      k_r        <= '0;
      i_r        <= '0;
      j_r        <= '0;
      best_r     <= '0;
      ovf_r      <= 1'b0;
      sfx_wr_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      last_idx_r <= last_idx_nxt;
      k_r        <= k_nxt;
      i_r        <= i_nxt;
      j_r        <= j_nxt;
      best_r     <= best_nxt;
      ovf_r      <= ovf_nxt;
      sfx_wr_r   <= sfx_wr_nxt;
    end
  end

  // Running maximum and the delayed suffix write address.
  always_ff @(posedge clk) begin
    run_max_r <= run_max_nxt;
    k_d_r     <= k_r;
  end

  // Element store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (q_pop && q_entry.wr) begin
      elem_mem[q_entry.idx] <= q_entry.value;
    end
    elem_rd_r <= elem_mem[elem_addr];
  end

  // Suffix-maximum store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (sfx_wr_r) begin
      sfx_mem[k_d_r] <= new_max;
    end
    sfx_rd_r <= sfx_mem[j_r];
  end

  // Result, saturated to the field width.
  assign best_ext  = CMP_W'(best_r);
  assign out_valid = (state_r == ST_OUT);
  always_comb begin
    out_res.overflow   = ovf_r;
    out_res.ramp_width = (best_ext > CMP_W'(WIDTH_MAX)) ? RAMP_W'(WIDTH_MAX)
                                                        : best_ext[RAMP_W-1:0];
  end

endmodule

### rtl/max_width_ramp_search.sv
// ============================================================================
// max_width_ramp_search: widest ramp over a loaded array of values
// Finds the largest j - i with element i not above element j.
// ============================================================================
// Usage:
//   A request (in_req.value, in_req.last) is taken at a rising edge with
//   start high and busy low. Each request adds one element; the request with
//   last set closes the array. Elements past MAX_LEN are dropped and flagged.
//   One result per array appears on out_res for a single cycle with out_valid
//   high. The receiver cannot stall, so nothing waits on the result side.
// Flow:
//   Requests enter a two-entry queue at one per cycle while busy is low; the
//   back part stores one element per cycle while it is loading. After the
//   closing request leaves the queue, the suffix-maximum pass walks the store
//   from the back, and the two-pointer scan runs a store read state and a
//   compare state per step, between n and 2n - 1 steps, before the result
//   issues; busy is high while the queue is full during that time. The
//   sustained cost per element is set by the single read port of each store.
// Reset:
//   rst_n low clears the counters, the queue and the sequencer; the stores
//   are not cleared and only entries of the current array are ever read.
// ============================================================================
module max_width_ramp_search #(
  parameter int unsigned MAX_LEN    = mwrs_pkg::MAX_LEN_DEF,
  parameter int unsigned VALUE_BITS = mwrs_pkg::VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  mwrs_pkg::in_req_t  in_req,
  output logic               busy,
  output logic               out_valid,
  output mwrs_pkg::out_res_t out_res
);
  import mwrs_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_LEN);

  // Queue entry: element, store address, and its classification.
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [IDX_W-1:0]      idx;
    logic                  wr;
    logic                  last;
    logic                  ovf;
  } entry_t;

  entry_t push_entry;
  entry_t pop_entry;
  logic   q_push, q_full, q_pop, q_valid;

  // Request intake.
  mwrs_front #(
    .MAX_LEN    (MAX_LEN),
    .VALUE_BITS (VALUE_BITS),
    .entry_t    (entry_t)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_req  (in_req),
    .busy    (busy),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (push_entry)
  );

  // Queue between intake and processing.
  mwrs_queue #(
    .entry_t (entry_t)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .valid      (q_valid),
    .pop_entry  (pop_entry)
  );

  // Storage, suffix pass and scan.
  mwrs_back #(
    .MAX_LEN    (MAX_LEN),
    .VALUE_BITS (VALUE_BITS),
    .entry_t    (entry_t)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_entry   (pop_entry),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule

### bench/tb.sv
// ============================================================================
// tb: self-checking bench for max_width_ramp_search
// Loads arrays one request at a time and checks each widest-ramp result,
// field by field, against a behavioral predictor kept in this bench, or the
// typed result of a directed row. A short table of directed arrays runs first.
// Random arrays follow, mostly short, plus one past the store depth for overflow.
// ============================================================================
module tb;
  import mwrs_pkg::*;

  localparam int unsigned MAX_LEN      = MAX_LEN_DEF;
  localparam int unsigned VALUE_BITS   = VALUE_BITS_DEF;
  localparam int unsigned RAND_ITEMS   = 730;
  localparam int unsigned STALL_LIMIT  = 20000;
  localparam int unsigned DRAIN_CYCLES = 50;
  localparam int unsigned SHOW_LIMIT   = 10;
  localparam int unsigned N_DIRECTED   = 20;

  // One directed row: a request, and the expected result where it is obvious.
  typedef struct packed {
    logic [IN_VALUE_W-1:0] value;
    logic                  last;
    logic                  typed;
    logic [RAMP_W-1:0]     width;
    logic                  ovf;
  } dir_row_t;

  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    // Single elements at both extremes.
    '{16'h0000, 1'b1, 1'b1, 10'd0, 1'b0},
    '{16'hFFFF, 1'b1, 1'b1, 10'd0, 1'b0},
    // Two elements: falling, rising and equal.
    '{16'hFFFF, 1'b0, 1'b0, 10'd0, 1'b0},
    '{16'h0000, 1'b1, 1'b1, 10'd0, 1'b0},
    '{16'h0000, 1'b0, 1'b0, 10'd0, 1'b0},
    '{16'hFFFF, 1'b1, 1'b1, 10'd1, 1'b0},
    '{16'h0005, 1'b0, 1'b0, 10'd0, 1'b0},
    '{16'h0005, 1'b1, 1'b1, 10'd1, 1'b0},
    // Strictly falling: no ramp at all.
    '{16'h0003, 1'b0, 1'b0, 10'd0, 1'b0},
    '{16'h0002, 1'b0, 1'b0, 10'd0, 1'b0},
    '{16'h0001, 1'b1, 1'b1, 10'd0, 1'b0},
    // Mixed array where the left index has to advance.
    '{16'h0006, 1'b0, 1'b0, 10'd0, 1'b0},
    '{16'h0000, 1'b0, 1'b0, 10'd0, 1'b0},
    '{16'h0008, 1'b0, 1'b0, 10'd0, 1'b0},
    '{16'h0002, 1'b0, 1'b0, 10'd0, 1'b0},
    '{16'h0001, 1'b0, 1'b0, 10'd0, 1'b0},
    '{16'h0005, 1'b1, 1'b0, 10'd0, 1'b0},
    // Alternating bit patterns.
    '{16'hAAAA, 1'b0, 1'b0, 10'd0, 1'b0},
    '{16'h5555, 1'b0, 1'b0, 10'd0, 1'b0},
    '{16'hAAAA, 1'b1, 1'b0, 10'd0, 1'b0}
  };

  logic     clk    = 1'b0;
  logic     rst_n  = 1'b0;
  logic     start  = 1'b0;
  in_req_t  in_req = '0;
  logic     busy;
  logic     out_valid;
  out_res_t out_res;

  max_width_ramp_search #(
    .MAX_LEN    (MAX_LEN),
    .VALUE_BITS (VALUE_BITS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_req    (in_req),
    .busy      (busy),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  always #4 clk = ~clk;

  // Predictor state: the array being loaded and its overflow flag.
  logic [VALUE_BITS-1:0] elem_mem [MAX_LEN];
  logic [VALUE_BITS-1:0] suffix_max [MAX_LEN];
  int unsigned           elem_cnt = 0;
  logic                  ovf_seen = 1'b0;

  out_res_t    ramp_q [$];
  int unsigned errors     = 0;
  int unsigned idle_run   = 0;
  bit          quiet      = 1'b0;

  // Widest ramp over the stored array, with a suffix maximum and two pointers.
  function automatic logic [RAMP_W-1:0] widest_ramp();
    int unsigned n, k, j, lo, best;
    n = elem_cnt;
    if (n == 0) return '0;
    suffix_max[n-1] = elem_mem[n-1];
    for (k = n - 1; k > 0; k--)
      suffix_max[k-1] = (elem_mem[k-1] > suffix_max[k]) ? elem_mem[k-1] : suffix_max[k];
    lo   = 0;
    best = 0;
    for (j = 0; j < n; j++) begin
      while (lo < j && elem_mem[lo] > suffix_max[j]) lo++;
      if (j - lo > best) best = j - lo;
    end
    if (best > WIDTH_MAX) best = WIDTH_MAX;
    return best[RAMP_W-1:0];
  endfunction

  // Adds one element to the predicted array; returns 1 when it closes one.
  function automatic bit take_element(input logic [IN_VALUE_W-1:0] v, input logic l,
                                      output out_res_t res);
    if (elem_cnt < MAX_LEN) begin
      elem_mem[elem_cnt] = v[VALUE_BITS-1:0];
      elem_cnt++;
    end else begin
      ovf_seen = 1'b1;
    end
    res = '0;
    if (!l) return 1'b0;
    res.ramp_width = widest_ramp();
    res.overflow   = ovf_seen;
    elem_cnt = 0;
    ovf_seen = 1'b0;
    return 1'b1;
  endfunction

  // Offers one request, sometimes after a random gap, and waits until taken.
  task automatic push_request(input logic [IN_VALUE_W-1:0] v, input logic l,
                              input bit typed, input out_res_t typed_res);
    int unsigned gap;
    out_res_t    pred;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < 30) gap = $urandom_range(1, 4);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req <= '{value: v, last: l};
    start  <= 1'b1;
    do @(posedge clk); while (busy);
    if (take_element(v, l, pred)) ramp_q.push_back(typed ? typed_res : pred);
  endtask

  // Result checker and stall watchdog.
  always @(posedge clk) begin
    out_res_t want;
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_run <= 0;
      else idle_run <= idle_run + 1;
      if (idle_run >= STALL_LIMIT) begin
        $display("tb: errors");
        $finish;
      end
      if (out_valid) begin
        if (ramp_q.size() == 0) begin
          errors <= errors + 1;
          if (errors < SHOW_LIMIT)
            $display("unexpected result: width %0d overflow %0b",
                     out_res.ramp_width, out_res.overflow);
        end else begin
          want = ramp_q.pop_front();
          if (want.ramp_width !== out_res.ramp_width || want.overflow !== out_res.overflow) begin
            errors <= errors + 1;
            if (errors < SHOW_LIMIT)
              $display("mismatch: width exp %0d got %0d, overflow exp %0b got %0b",
                       want.ramp_width, out_res.ramp_width, want.overflow, out_res.overflow);
          end
        end
      end
    end
  end

  // Stimulus: reset, directed table, random arrays, then drain.
  initial begin
    int unsigned rand_items, len, mode, i, base;
    logic [IN_VALUE_W-1:0] v;
    out_res_t typed_res;
    bit big_done;
    rand_items = 0;
    big_done   = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < N_DIRECTED; i++) begin
      typed_res = '{ramp_width: DIRECTED[i].width, overflow: DIRECTED[i].ovf};
      push_request(DIRECTED[i].value, DIRECTED[i].last, DIRECTED[i].typed, typed_res);
    end

    while (rand_items < RAND_ITEMS) begin
      // Halfway through, one array longer than the store to force overflow.
      if (!big_done && rand_items >= RAND_ITEMS / 2) begin
        big_done = 1'b1;
        len = MAX_LEN + $urandom_range(1, 4);
        for (i = 0; i < len; i++) begin
          v = (i == 0) ? IN_VALUE_W'($urandom_range(0, 15)) : IN_VALUE_W'($urandom);
          push_request(v, i == len - 1, 1'b0, '0);
        end
      end
      len  = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 8) : $urandom_range(9, 40);
      mode = $urandom_range(0, 3);
      base = $urandom_range(0, 2000);
      // A long stretch in the middle runs without any gaps.
      quiet = (rand_items >= 250 && rand_items < 450);
      for (i = 0; i < len; i++) begin
        case (mode)
          0: begin
            v = IN_VALUE_W'($urandom);
          end
          1: begin
            v = IN_VALUE_W'($urandom_range(0, 7));
          end
          2: begin
            base = base + $urandom_range(0, 3);
            v = IN_VALUE_W'(base);
          end
          default: begin
            base = base + $urandom_range(0, 3);
            v = 16'hFFFF - IN_VALUE_W'(base);
          end
        endcase
        push_request(v, i == len - 1, 1'b0, '0);
        rand_items++;
      end
    end
    quiet = 1'b0;
    start <= 1'b0;

    while (ramp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
